### sv/dap_pkg.sv
`timescale 1ns / 1ps
package dap_pkg;
  localparam int IN_WIDTH_DEF   = 16;
  localparam int STAGES_DEF     = 16;
  localparam int TAB_LEN        = 24;
  localparam int W              = 48;
  localparam int AW             = 32;
  localparam logic signed [AW-1:0] ANG_HALF    = 32'sd11796480;
  localparam logic signed [AW-1:0] ANG_QUARTER = 32'sd5898240;
  localparam logic signed [W-1:0]  INV_GAIN    = 48'sd10188014;
  localparam int OUT_MAX = 11520;

  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0: v = 32'sd2949120;   5'd1: v = 32'sd1740967; 5'd2: v = 32'sd919879;
      5'd3: v = 32'sd466945;    5'd4: v = 32'sd234379;  5'd5: v = 32'sd117304;
      5'd6: v = 32'sd58666;     5'd7: v = 32'sd29335;   5'd8: v = 32'sd14668;
      5'd9: v = 32'sd7334;      5'd10: v = 32'sd3667;   5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;      5'd13: v = 32'sd458;    5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;      5'd16: v = 32'sd57;     5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;       5'd19: v = 32'sd7;      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;        5'd22: v = 32'sd1;      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic                 vld;
    logic                 inv;
    logic                 onz;
    logic                 nzneg;
    logic                 neg;
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [AW-1:0] z;
    logic signed [W-1:0]  nz;
    logic signed [AW-1:0] phi;
    logic signed [AW-1:0] theta;
  } item_t;
endpackage

### sv/dap_cordic_stage.sv
`timescale 1ns / 1ps
// One registered CORDIC iteration, vectoring or rotation mode.
module dap_cordic_stage #(
  parameter int IDX = 0,
  parameter bit ROT = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dap_pkg::item_t d,
  output dap_pkg::item_t q
);
  dap_pkg::item_t q_r, q_nxt;
  logic signed [dap_pkg::W-1:0]  dx, dy;
  logic signed [dap_pkg::AW-1:0] at;
  logic up;

  // Compute one micro-rotation
  always_comb begin
    dx = d.y >>> IDX;
    dy = d.x >>> IDX;
    at = dap_pkg::atan_tab(5'(IDX));
    up = ROT ? (d.z >= 0) : (d.y < 0);
    q_nxt = d;
    if (up) begin
      q_nxt.x = d.x - dx; q_nxt.y = d.y + dy; q_nxt.z = d.z - at;
    end else begin
      q_nxt.x = d.x + dx; q_nxt.y = d.y - dy; q_nxt.z = d.z + at;
    end
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (!rst_n) q_r.vld <= 1'b0;
    else q_r.vld <= d.vld;
    q_r.inv <= q_nxt.inv; q_r.onz <= q_nxt.onz; q_r.nzneg <= q_nxt.nzneg;
    q_r.neg <= q_nxt.neg; q_r.x <= q_nxt.x; q_r.y <= q_nxt.y; q_r.z <= q_nxt.z;
    q_r.nz <= q_nxt.nz; q_r.phi <= q_nxt.phi; q_r.theta <= q_nxt.theta;
  end

  assign q = q_r;
endmodule

### sv/dap_cordic_chain.sv
`timescale 1ns / 1ps
// Chain of STAGES registered CORDIC iterations.
module dap_cordic_chain #(
  parameter int STAGES = dap_pkg::STAGES_DEF,
  parameter bit ROT    = 1'b0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dap_pkg::item_t d,
  output dap_pkg::item_t q
);
  dap_pkg::item_t s [STAGES+1];
  assign s[0] = d;
  for (genvar i = 0; i < STAGES; i++) begin : g_st
    dap_cordic_stage #(.IDX(i), .ROT(ROT)) u_st (
      .clk(clk), .rst_n(rst_n), .d(s[i]), .q(s[i+1]));
  end
  assign q = s[STAGES];
endmodule

### sv/dap_gain_mul.sv
`timescale 1ns / 1ps
// Registered multiply by the inverse CORDIC gain, split in two partial products.
module dap_gain_mul (
  input  logic                         clk,
  input  logic signed [dap_pkg::W-1:0] a,
  output logic signed [dap_pkg::W+24:0] p
);
  logic signed [dap_pkg::W+24:0] lo_r, hi_r, p_r;
  // Stage one: low 24 bits and high part of a
  always_ff @(posedge clk) begin
    lo_r <= (dap_pkg::W+25)'($signed({1'b0, a[23:0]}) * dap_pkg::INV_GAIN);
    hi_r <= (dap_pkg::W+25)'($signed(a[dap_pkg::W-1:24]) * dap_pkg::INV_GAIN);
  end
  // Stage two: combine
  always_ff @(posedge clk) p_r <= lo_r + (hi_r <<< 24);
  assign p = p_r;
endmodule

### sv/direction_to_angle_projection_unit.sv
`timescale 1ns / 1ps
// Channel  | ports                                     | handshake
// input    | start, busy, in_dir_x/y/z                 | start & !busy
// result   | out_valid, out_polar/azimuth/proj_x/proj_y | one-cycle strobe
// busy is always low: a transaction enters every cycle.
// The path runs through three chained CORDIC pipelines
// (phi vectoring, theta vectoring, projection rotation) plus gain multipliers.
// Synchronous active-low reset clears the valid bits; payload is not reset.
// The receiver cannot stall, so the pipeline never stops.
module direction_to_angle_projection_unit #(
  parameter int IN_WIDTH      = dap_pkg::IN_WIDTH_DEF,
  parameter int CORDIC_STAGES = dap_pkg::STAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] in_dir_x,
  input  logic signed [IN_WIDTH-1:0] in_dir_y,
  input  logic signed [IN_WIDTH-1:0] in_dir_z,
  output logic                       out_valid,
  output logic [13:0]                out_polar_angle,
  output logic signed [14:0]         out_azimuth_angle,
  output logic signed [14:0]         out_proj_x_angle,
  output logic signed [14:0]         out_proj_y_angle,
  output logic                       out_invalid
);
  localparam int W = dap_pkg::W;
  localparam int AW = dap_pkg::AW;
  localparam int SH = 36 - IN_WIDTH;

  dap_pkg::item_t a_r, a_nxt, v1_q, b_r, b_nxt, c_r, c_nxt, v2_q, d_r, d_nxt, r_q;
  logic signed [W-1:0] nx, ny, nzv, ax, ay;
  logic signed [W+24:0] m1, mx, my;
  dap_pkg::item_t m1a_r, m1b_r, e_r, e2_r;
  logic signed [W-1:0] r;
  logic signed [W+24:0] px, py;
  logic signed [AW-1:0] th_rnd, ph_rnd;

  assign busy = 1'b0;

  // Negate and scale inputs, set up phi vectoring
  always_comb begin
    nx  = -(W'(in_dir_x) <<< SH);
    ny  = -(W'(in_dir_y) <<< SH);
    nzv = -(W'(in_dir_z) <<< SH);
    a_nxt = '0;
    a_nxt.vld = start;
    a_nxt.inv = (nx == 0) && (ny == 0) && (nzv == 0);
    a_nxt.onz = (nx == 0) && (ny == 0);
    a_nxt.nz = nzv;
    ax = nx; ay = ny;
    if (nx < 0) begin
      ax = -nx; ay = -ny;
      a_nxt.z = (ny >= 0) ? dap_pkg::ANG_HALF : -dap_pkg::ANG_HALF;
    end
    a_nxt.x = ax; a_nxt.y = ay;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) a_r.vld <= 1'b0;
    else a_r.vld <= a_nxt.vld;
    a_r.inv <= a_nxt.inv; a_r.onz <= a_nxt.onz; a_r.nzneg <= 1'b0; a_r.neg <= 1'b0;
    a_r.x <= a_nxt.x; a_r.y <= a_nxt.y; a_r.z <= a_nxt.z; a_r.nz <= a_nxt.nz;
    a_r.phi <= '0; a_r.theta <= '0;
  end

  dap_cordic_chain #(.STAGES(CORDIC_STAGES), .ROT(1'b0)) u_phi (
    .clk(clk), .rst_n(rst_n), .d(a_r), .q(v1_q));

  // Scale radius by inverse gain
  dap_gain_mul u_m1 (.clk(clk), .a(v1_q.x), .p(m1));
  always_ff @(posedge clk) begin
    if (!rst_n) begin m1a_r.vld <= 1'b0; m1b_r.vld <= 1'b0; end
    else begin m1a_r.vld <= v1_q.vld; m1b_r.vld <= m1a_r.vld; end
    m1a_r.inv <= v1_q.inv; m1a_r.onz <= v1_q.onz; m1a_r.nzneg <= 1'b0;
    m1a_r.neg <= 1'b0; m1a_r.x <= '0; m1a_r.y <= '0; m1a_r.nz <= v1_q.nz;
    m1a_r.z <= v1_q.z; m1a_r.phi <= '0; m1a_r.theta <= '0;
    m1b_r.inv <= m1a_r.inv; m1b_r.onz <= m1a_r.onz; m1b_r.nzneg <= 1'b0;
    m1b_r.neg <= 1'b0; m1b_r.x <= '0; m1b_r.y <= '0; m1b_r.nz <= m1a_r.nz;
    m1b_r.z <= m1a_r.z; m1b_r.phi <= '0; m1b_r.theta <= '0;
  end

  // Set up theta vectoring
  always_comb begin
    r = W'((m1 + (W+25)'(64'sd1 <<< 23)) >>> 24);
    b_nxt = m1b_r;
    b_nxt.phi = m1b_r.onz ? '0 : m1b_r.z;
    if (m1b_r.onz) r = '0;
    if (m1b_r.nz < 0) begin
      b_nxt.x = r; b_nxt.y = -m1b_r.nz; b_nxt.z = dap_pkg::ANG_QUARTER;
    end else begin
      b_nxt.x = m1b_r.nz; b_nxt.y = r; b_nxt.z = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b_r.vld <= 1'b0;
    else b_r.vld <= b_nxt.vld;
    b_r.inv <= b_nxt.inv; b_r.onz <= b_nxt.onz; b_r.nzneg <= 1'b0; b_r.neg <= 1'b0;
    b_r.x <= b_nxt.x; b_r.y <= b_nxt.y; b_r.z <= b_nxt.z; b_r.nz <= b_nxt.nz;
    b_r.phi <= b_nxt.phi; b_r.theta <= '0;
  end

  dap_cordic_chain #(.STAGES(CORDIC_STAGES), .ROT(1'b0)) u_theta (
    .clk(clk), .rst_n(rst_n), .d(b_r), .q(v2_q));

  // Fold phi into the right half plane, set up rotation
  always_comb begin
    c_nxt = v2_q;
    c_nxt.theta = v2_q.z;
    c_nxt.z = v2_q.phi;
    c_nxt.neg = 1'b0;
    if (v2_q.phi > dap_pkg::ANG_QUARTER) begin
      c_nxt.z = v2_q.phi - dap_pkg::ANG_HALF; c_nxt.neg = 1'b1;
    end else if (v2_q.phi < -dap_pkg::ANG_QUARTER) begin
      c_nxt.z = v2_q.phi + dap_pkg::ANG_HALF; c_nxt.neg = 1'b1;
    end
    c_nxt.x = W'(v2_q.z);
    c_nxt.y = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c_r.vld <= 1'b0;
    else c_r.vld <= c_nxt.vld;
    c_r.inv <= c_nxt.inv; c_r.onz <= c_nxt.onz; c_r.nzneg <= 1'b0; c_r.neg <= c_nxt.neg;
    c_r.x <= c_nxt.x; c_r.y <= c_nxt.y; c_r.z <= c_nxt.z; c_r.nz <= '0;
    c_r.phi <= c_nxt.phi; c_r.theta <= c_nxt.theta;
  end

  dap_cordic_chain #(.STAGES(CORDIC_STAGES), .ROT(1'b1)) u_rot (
    .clk(clk), .rst_n(rst_n), .d(c_r), .q(r_q));

  // Apply sign fold
  always_comb begin
    d_nxt = r_q;
    if (r_q.neg) begin d_nxt.x = -r_q.x; d_nxt.y = -r_q.y; end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) d_r.vld <= 1'b0;
    else d_r.vld <= d_nxt.vld;
    d_r.inv <= d_nxt.inv; d_r.onz <= 1'b0; d_r.nzneg <= 1'b0; d_r.neg <= 1'b0;
    d_r.x <= d_nxt.x; d_r.y <= d_nxt.y; d_r.z <= '0; d_r.nz <= '0;
    d_r.phi <= d_nxt.phi; d_r.theta <= d_nxt.theta;
  end

  dap_gain_mul u_mx (.clk(clk), .a(d_r.x), .p(mx));
  dap_gain_mul u_my (.clk(clk), .a(d_r.y), .p(my));
  always_ff @(posedge clk) begin
    if (!rst_n) begin e_r.vld <= 1'b0; e2_r.vld <= 1'b0; end
    else begin e_r.vld <= d_r.vld; e2_r.vld <= e_r.vld; end
    e_r.inv <= d_r.inv; e_r.onz <= 1'b0; e_r.nzneg <= 1'b0; e_r.neg <= 1'b0;
    e_r.x <= '0; e_r.y <= '0; e_r.z <= '0; e_r.nz <= '0;
    e_r.phi <= d_r.phi; e_r.theta <= d_r.theta;
    e2_r.inv <= e_r.inv; e2_r.onz <= 1'b0; e2_r.nzneg <= 1'b0; e2_r.neg <= 1'b0;
    e2_r.x <= '0; e2_r.y <= '0; e2_r.z <= '0; e2_r.nz <= '0;
    e2_r.phi <= e_r.phi; e2_r.theta <= e_r.theta;
  end

  // Round, saturate and register the result
  logic out_valid_r, out_invalid_r;
  logic [13:0] pol_r;
  logic signed [14:0] az_r, px_r, py_r;
  always_comb begin
    th_rnd = (e2_r.theta + AW'(512)) >>> 10;
    ph_rnd = (e2_r.phi + AW'(512)) >>> 10;
    px = (mx + (W+25)'(64'sd1 <<< 33)) >>> 34;
    py = (my + (W+25)'(64'sd1 <<< 33)) >>> 34;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= e2_r.vld;
    out_invalid_r <= e2_r.inv;
    if (e2_r.inv) begin
      pol_r <= '0; az_r <= '0; px_r <= '0; py_r <= '0;
    end else begin
      pol_r <= (th_rnd < 0) ? 14'd0 : (th_rnd > AW'(dap_pkg::OUT_MAX)) ?
               14'(dap_pkg::OUT_MAX) : th_rnd[13:0];
      az_r <= (ph_rnd < -AW'(dap_pkg::OUT_MAX)) ? -15'(dap_pkg::OUT_MAX) :
              (ph_rnd > AW'(dap_pkg::OUT_MAX)) ? 15'(dap_pkg::OUT_MAX) : ph_rnd[14:0];
      px_r <= (px < -(W+25)'(dap_pkg::OUT_MAX)) ? -15'(dap_pkg::OUT_MAX) :
              (px > (W+25)'(dap_pkg::OUT_MAX)) ? 15'(dap_pkg::OUT_MAX) : px[14:0];
      py_r <= (py < -(W+25)'(dap_pkg::OUT_MAX)) ? -15'(dap_pkg::OUT_MAX) :
              (py > (W+25)'(dap_pkg::OUT_MAX)) ? 15'(dap_pkg::OUT_MAX) : py[14:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_invalid       = out_invalid_r;
  assign out_polar_angle   = pol_r;
  assign out_azimuth_angle = az_r;
  assign out_proj_x_angle  = px_r;
  assign out_proj_y_angle  = py_r;
endmodule
